/* sv/ofdm_carrier_interleaver_core_defines.svh */
// Assertion macros for the carrier interleaver RTL.
// Depends on nothing. Files that check their own logic include this header.
`ifndef OFDM_CARRIER_INTERLEAVER_CORE_DEFINES_SVH
`define OFDM_CARRIER_INTERLEAVER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define OCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled during reset.
`define OCI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define OCI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/oci_pkg.sv */
// Types, constants and helper functions for the carrier interleaver.
// Depends on nothing; every other file but the assertion macro header imports it.
`timescale 1ns / 1ps
`default_nettype none
package oci_pkg;
	localparam int CARRIER_W = 11;
	localparam int BIN_W     = 12;
	localparam int MODE_W    = 3;
	localparam int FFT_W     = 13;
	localparam int LEN_W     = 12;
	localparam int OFF_W     = 11;
	localparam int IDX_W     = 11;
	localparam int PROD_W    = 15;
	localparam int CFG_IDX_W = 1;

	localparam logic [PROD_W-1:0] GEN_MULT  = 15'd13;
	localparam logic [MODE_W-1:0] MODE_RST  = 3'd1;
	localparam logic [FFT_W-1:0]  FFT_RST   = 13'd2048;

	// Transmission mode codes, lowest to highest.
	localparam logic [MODE_W-1:0] MODE_2K   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_512  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_256  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_1K   = 3'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE     = 1'b0,
		CFG_FFT_SIZE = 1'b1
	} cfg_reg_t;

	// One write into the offset table.
	typedef struct packed {
		logic                    we;
		logic [IDX_W-1:0]        addr;
		logic signed [OFF_W-1:0] data;
	} tbl_wr_t;

	// Table builder status seen by the lookup path.
	typedef struct packed {
		logic             building;
		logic [IDX_W-1:0] fill;
	} gen_stat_t;

	// Interleaver length N for a transmission mode; zero for undefined codes.
	function automatic logic [LEN_W-1:0] mode_len(input logic [MODE_W-1:0] m);
		logic [LEN_W-1:0] n;
		unique case (m)
			MODE_2K:  n = 12'd2048;
			MODE_512: n = 12'd512;
			MODE_256: n = 12'd256;
			MODE_1K:  n = 12'd1024;
			default:  n = '0;
		endcase
		return n;
	endfunction

	function automatic logic mode_ok(input logic [MODE_W-1:0] m);
		return (m >= MODE_2K) && (m <= MODE_1K);
	endfunction
endpackage
`default_nettype wire

/* sv/oci_if.sv */
// Valid/ready channel interfaces for carrier lookups and their results.
// Depends on oci_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none
interface oci_in_if;
	import oci_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CARRIER_W-1:0] carrier_index;
	modport source (output valid, output carrier_index, input ready);
	modport sink   (input valid, input carrier_index, output ready);
endinterface

interface oci_out_if;
	import oci_pkg::*;
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] fft_bin;
	logic             index_error;
	modport source (output valid, output fft_bin, output index_error, input ready);
	modport sink   (input valid, input fft_bin, input index_error, output ready);
endinterface
`default_nettype wire

/* sv/ofdm_carrier_interleaver_core.sv */
// Carrier interleaver top level. A result passes the stage-one and stage-two registers
// after its transfer in. Throughput: one lookup per cycle while no build runs and the
// output is not stalled, set by the single read port of the offset table. The table is
// built after reset and after each valid mode write; the input is not ready meanwhile.
// Reset (arst_n, asynchronous, active low) selects mode 1, FFT size 2048, and starts the build.
// Depends on oci_pkg, oci_if, oci_gen, oci_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "ofdm_carrier_interleaver_core_defines.svh"
module ofdm_carrier_interleaver_core #(
	parameter int MAX_CARRIERS = 1536
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	oci_in_if.sink                               carrier_in,
	oci_out_if.source                            bin_out,
	input  wire logic                            cfg_we,
	input  wire logic [oci_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [oci_pkg::FFT_W-1:0]       cfg_data
);
	import oci_pkg::*;

	// Configuration. A mode write with an undefined code is dropped, so the old
	// table stays in force; a defined code restarts the table build at once.
	logic [FFT_W-1:0] fft_size_q;
	logic             gen_start;

	assign gen_start = cfg_we && (cfg_index == CFG_MODE) && mode_ok(cfg_data[MODE_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fft_size_q <= FFT_RST;
		end else if (cfg_we && (cfg_index == CFG_FFT_SIZE)) begin
			fft_size_q <= cfg_data;
		end
	end

	// The builder walks the generator sequence and fills the table in order,
	// reporting how many offsets it stored; that count is the carrier limit.
	tbl_wr_t   tbl_wr;
	gen_stat_t gen_stat;

	oci_gen #(
		.MAX_CARRIERS(MAX_CARRIERS)
	) u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (gen_start),
		.start_mode(cfg_data[MODE_W-1:0]),
		.wr        (tbl_wr),
		.stat      (gen_stat)
	);

	// Two-stage lookup. The whole pipe advances whenever the output register is
	// empty or its result is being transferred out; the table read is enabled
	// on the same condition so that a stalled read keeps its data.
	logic adv;
	logic in_xfer;

	assign adv              = !bin_out.valid || bin_out.ready;
	assign carrier_in.ready = !gen_stat.building && adv;
	assign in_xfer          = carrier_in.valid && carrier_in.ready;

	logic signed [OFF_W-1:0] rd_data_s1;

	oci_ram #(
		.DEPTH(MAX_CARRIERS)
	) u_ram (
		.clk    (clk),
		.wr     (tbl_wr),
		.rd_en  (adv),
		.rd_addr(IDX_W'(carrier_in.carrier_index)),
		.rd_data(rd_data_s1)
	);

	// Stage one holds the range check alongside the table read.
	logic valid_s1;
	logic err_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s1 <= IDX_W'(carrier_in.carrier_index) >= gen_stat.fill;
		end
	end

	// Stage two: negative offsets wrap by the FFT size, modulo the bin width.
	// An out-of-range index reports bin zero with the error flag set.
	logic [BIN_W-1:0] off_ext;
	logic [BIN_W-1:0] wrapped;
	logic [BIN_W-1:0] bin_d;

	assign off_ext = {rd_data_s1[OFF_W-1], rd_data_s1};
	assign wrapped = fft_size_q[BIN_W-1:0] + off_ext;

	always_comb begin
		if (err_s1) begin
			bin_d = '0;
		end else if (rd_data_s1[OFF_W-1]) begin
			bin_d = wrapped;
		end else begin
			bin_d = off_ext;
		end
	end

	logic             out_valid_s2;
	logic [BIN_W-1:0] bin_s2;
	logic             err_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s2 <= bin_d;
			err_s2 <= err_s1;
		end
	end

	assign bin_out.valid       = out_valid_s2;
	assign bin_out.fft_bin     = bin_s2;
	assign bin_out.index_error = err_s2;

	// No lookup may be taken while the table is being rebuilt.
	`OCI_ASSERT_IMP(a_no_lookup_in_build, clk, arst_n, gen_stat.building, !carrier_in.ready, "lookup ready during table build")
	// Table writes come only from an active build.
	`OCI_ASSERT_IMP(a_write_in_build, clk, arst_n, tbl_wr.we, gen_stat.building, "table written outside a build")
	// The stored count never exceeds the table depth.
	`OCI_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, gen_stat.fill <= IDX_W'(MAX_CARRIERS), "fill count beyond table depth")
	// An error result always carries bin zero.
	`OCI_ASSERT_IMP(a_err_bin_zero, clk, arst_n, bin_out.valid && bin_out.index_error, bin_out.fft_bin == '0, "error result with nonzero bin")
	// A transfer in reaches stage one in the next cycle.
	`OCI_ASSERT_NXT(a_xfer_to_s1, clk, arst_n, in_xfer, valid_s1, "accepted lookup lost before stage one")
endmodule
`default_nettype wire

/* sv/oci_ram.sv */
// Offset table storage: one write port, one registered read port.
// Depends on oci_pkg for the write struct and widths.
`timescale 1ns / 1ps
`default_nettype none
module oci_ram #(
	parameter int DEPTH = 1536
) (
	input  wire logic                             clk,
	input  wire oci_pkg::tbl_wr_t                 wr,
	input  wire logic                             rd_en,
	input  wire logic [oci_pkg::IDX_W-1:0]        rd_addr,
	output      logic signed [oci_pkg::OFF_W-1:0] rd_data
);
	import oci_pkg::*;
	localparam int AW = $clog2(DEPTH);

	logic signed [OFF_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr[AW-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr[AW-1:0]];
		end
	end
endmodule
`default_nettype wire

/* sv/oci_gen.sv */
// Table builder: steps the interleaver generator once a cycle while a build runs and emits
// table writes. Depends on oci_pkg.
`timescale 1ns / 1ps
`default_nettype none
module oci_gen #(
	parameter int MAX_CARRIERS = 1536
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [oci_pkg::MODE_W-1:0]  start_mode,
	output      oci_pkg::tbl_wr_t            wr,
	output      oci_pkg::gen_stat_t          stat
);
	import oci_pkg::*;
	localparam int FW = $clog2(MAX_CARRIERS + 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(MAX_CARRIERS);

	logic [MODE_W-1:0]    mode_q;
	logic                 building_q;
	logic [CARRIER_W-1:0] a_q;
	logic [CARRIER_W-1:0] step_q;
	logic [FW-1:0]        fill_q;

	logic [LEN_W-1:0]     len;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W-1:0]    sum;
	logic [CARRIER_W-1:0] a_next;
	logic [LEN_W-1:0]     a_ext;
	logic                 keep;
	logic                 last;

	assign len    = mode_len(mode_q);
	assign prod   = PROD_W'(a_q) * GEN_MULT;
	assign sum    = prod + PROD_W'(len >> 2) - PROD_W'(1);
	assign a_next = CARRIER_W'(sum & PROD_W'(len - LEN_W'(1)));
	assign a_ext  = LEN_W'(a_next);
	// Keep values in the central band, dropping the centre (DC) carrier.
	assign keep   = (a_ext >= (len >> 3)) && (a_ext <= (len - (len >> 3)))
		&& (a_ext != (len >> 1));
	assign last   = (step_q == CARRIER_W'(len - LEN_W'(2)));

	assign wr.we   = building_q && keep && (fill_q < FILL_MAX);
	assign wr.addr = IDX_W'(fill_q);
	assign wr.data = OFF_W'(a_next - CARRIER_W'(len >> 1));

	assign stat.building = building_q;
	assign stat.fill     = IDX_W'(fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RST;
			building_q <= 1'b1;
			a_q        <= '0;
			step_q     <= '0;
			fill_q     <= '0;
		end else if (start) begin
			mode_q     <= start_mode;
			building_q <= 1'b1;
			a_q        <= '0;
			step_q     <= '0;
			fill_q     <= '0;
		end else if (building_q) begin
			a_q    <= a_next;
			step_q <= step_q + CARRIER_W'(1);
			if (wr.we) begin
				fill_q <= fill_q + FW'(1);
			end
			if (last) begin
				building_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

/* bench/oci_bin_checker.sv */
// Scoreboard for the carrier interleaver: follows the register writes and both channels,
// keeps its own copy of the offset table, and compares every result with its prediction.
// Depends on oci_pkg and the channel interfaces in oci_if.
`timescale 1ns / 1ps
module oci_bin_checker #(
	parameter int MAX_CARRIERS = 1536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	oci_in_if                             carrier_in,
	oci_out_if                            bin_out,
	input  logic                          cfg_we,
	input  logic [oci_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [oci_pkg::FFT_W-1:0]     cfg_data,
	output int                            mismatches,
	output int                            bins_pending
);
	import oci_pkg::*;

	typedef struct packed {
		logic [CARRIER_W-1:0] idx;
		logic [BIN_W-1:0]     bin;
		logic                 err;
	} bin_result_t;

	logic signed [OFF_W-1:0] carrier_offsets [MAX_CARRIERS];
	int                      offsets_filled;
	logic [MODE_W-1:0]       cur_mode;
	logic [FFT_W-1:0]        cur_fft;
	bin_result_t             bins_due [$];
	int                      fail_count = 0;

	function automatic int interleaver_len(input logic [MODE_W-1:0] m);
		int n;
		case (m)
			MODE_2K:  n = 2048;
			MODE_512: n = 512;
			MODE_256: n = 256;
			MODE_1K:  n = 1024;
			default:  n = 0;
		endcase
		return n;
	endfunction

	// Runs the carrier generator for the current mode and keeps the central band.
	function void rebuild_offsets();
		int n;
		int a;
		n = interleaver_len(cur_mode);
		a = 0;
		offsets_filled = 0;
		for (int i = 1; i < n; i++) begin
			a = (13 * a + n / 4 - 1) % n;
			if (a >= n / 8 && a <= 7 * n / 8 && a != n / 2 && offsets_filled < MAX_CARRIERS) begin
				carrier_offsets[offsets_filled] = OFF_W'(a - n / 2);
				offsets_filled++;
			end
		end
	endfunction

	function bin_result_t lookup_bin(input logic [CARRIER_W-1:0] idx);
		bin_result_t r;
		int          off;
		int          v;
		r.idx = idx;
		if (int'(idx) >= offsets_filled || int'(idx) >= MAX_CARRIERS) begin
			r.bin = '0;
			r.err = 1'b1;
		end else begin
			off = int'(carrier_offsets[idx]);
			v   = (off >= 0) ? off : int'(cur_fft) + off;
			r.bin = BIN_W'(v);
			r.err = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bin_result_t want;
		if (!arst_n) begin
			cur_mode = MODE_RST;
			cur_fft  = FFT_RST;
			rebuild_offsets();
			bins_due.delete();
		end else begin
			// Results are retired before new lookups are queued at the same edge.
			if (bin_out.valid && bin_out.ready) begin
				if (bins_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: bin %0d err %0b", bin_out.fft_bin,
							bin_out.index_error);
				end else begin
					want = bins_due.pop_front();
					if (bin_out.fft_bin !== want.bin || bin_out.index_error !== want.err) begin
						fail_count++;
						if (fail_count <= 10)
							$display("carrier %0d: expected bin %0d err %0b, got bin %0d err %0b",
								want.idx, want.bin, want.err, bin_out.fft_bin, bin_out.index_error);
					end
				end
			end
			if (carrier_in.valid && carrier_in.ready)
				bins_due.push_back(lookup_bin(carrier_in.carrier_index));
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_MODE: begin
						// Undefined mode codes leave the mode and its table alone.
						if (interleaver_len(cfg_data[MODE_W-1:0]) != 0) begin
							cur_mode = cfg_data[MODE_W-1:0];
							rebuild_offsets();
						end
					end
					CFG_FFT_SIZE: begin
						cur_fft = cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
		bins_pending <= bins_due.size();
		mismatches   <= fail_count;
	end
endmodule

/* bench/ofdm_carrier_interleaver_core_tb.sv */
// Top of the carrier interleaver testbench: clock, reset, stimulus and the verdict.
// Depends on oci_pkg, oci_if, the block itself and oci_bin_checker.
`timescale 1ns / 1ps
module ofdm_carrier_interleaver_core_tb;
	import oci_pkg::*;

	localparam int MAX_CARRIERS = 1536;
	// A result passes both pipeline stages after its transfer in; the slack covers that with room to spare.
	localparam int SETTLE_CYCLES = 6;
	// Table builds after every valid mode write dominate the run; this bound is far beyond them.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 125;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FFT_W-1:0]     cfg_data;
	int                   mismatches;
	int                   bins_pending;

	// The mode the block is running with, so that stimulus can aim at valid carriers.
	logic [MODE_W-1:0]    live_mode;
	int                   burst_left;
	int                   cycle_count = 0;
	logic [31:0]          stall_word = '1;
	logic [5:0]           stall_tick = '0;

	oci_in_if  carrier_ch ();
	oci_out_if bin_ch ();

	ofdm_carrier_interleaver_core #(
		.MAX_CARRIERS(MAX_CARRIERS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.carrier_in(carrier_ch),
		.bin_out   (bin_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	oci_bin_checker #(
		.MAX_CARRIERS(MAX_CARRIERS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.carrier_in  (carrier_ch),
		.bin_out     (bin_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.bins_pending(bins_pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// The run is cut short here if the block stops producing results.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// The result side stalls on a rotating pattern word. A new word is chosen whenever the
	// tick counter wraps: sometimes all ones, so that long stretches run without a stall, and
	// otherwise plain, dense or sparse random patterns. Bit zero is forced high in the sparse
	// case so that no pattern can stall the receiver for good.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 6'd1;
		if (stall_tick == '0) begin
			case ($urandom_range(0, 3))
				0: stall_word <= '1;
				1: stall_word <= $urandom;
				2: stall_word <= $urandom | $urandom;
				default: stall_word <= ($urandom & $urandom) | 32'h1;
			endcase
		end else begin
			stall_word <= {stall_word[0], stall_word[31:1]};
		end
		bin_ch.ready <= stall_word[0];
	end

	// Number of carriers that map to a bin in a given mode, bounded by the table depth.
	function automatic int carriers_for(input logic [MODE_W-1:0] m);
		int k;
		case (m)
			MODE_2K:  k = 1536;
			MODE_512: k = 384;
			MODE_256: k = 192;
			MODE_1K:  k = 768;
			default:  k = 0;
		endcase
		return (k > MAX_CARRIERS) ? MAX_CARRIERS : k;
	endfunction

	// Offers one carrier index and returns at the edge where it is transferred. The
	// sender works in bursts: when a burst runs out, valid drops for a random gap
	// (sometimes none at all) and a new burst length is drawn. Valid stays high
	// between items of one burst, so it is never lowered and raised in one step.
	task automatic push_carrier(input logic [CARRIER_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				carrier_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		carrier_ch.valid         <= 1'b1;
		carrier_ch.carrier_index <= idx;
		do @(posedge clk); while (!carrier_ch.ready);
		burst_left--;
	endtask

	// Holds the sender back until every predicted result has been transferred out,
	// then lets the pipeline drain for the SETTLE_CYCLES slack.
	task automatic settle();
		carrier_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (bins_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write enable is left high so that back-to-back writes need no second assignment.
	task automatic write_reg(input cfg_reg_t which, input logic [FFT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// New settings are applied only once the block is idle. The FFT size goes first,
	// as a mode write starts a table build and the block is busy until it ends.
	task automatic configure(input logic [FFT_W-1:0] fft, input logic [FFT_W-1:0] mode_word);
		settle();
		write_reg(CFG_FFT_SIZE, fft);
		write_reg(CFG_MODE, mode_word);
		cfg_we <= 1'b0;
		if (carriers_for(mode_word[MODE_W-1:0]) != 0)
			live_mode = mode_word[MODE_W-1:0];
	endtask

	// Mostly carriers that exist in the current mode, with the rest anywhere in the field
	// so that the index check and every bit of the index are exercised.
	function automatic logic [CARRIER_W-1:0] pick_index(input int k);
		if ($urandom_range(0, 4) != 0)
			return CARRIER_W'($urandom_range(0, k - 1));
		return CARRIER_W'($urandom);
	endfunction

	initial begin
		logic [FFT_W-1:0] fft;
		logic [FFT_W-1:0] mode_word;
		int               k;
		int               pick;

		arst_n                   <= 1'b0;
		cfg_we                   <= 1'b0;
		cfg_index                <= CFG_MODE;
		cfg_data                 <= '0;
		carrier_ch.valid         <= 1'b0;
		carrier_ch.carrier_index <= '0;
		live_mode   = MODE_RST;
		burst_left  = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings. The first transfer waits for the table built after reset.
		// The first and last carriers, the first index past the carrier count, the
		// largest index, and alternating bit patterns.
		push_carrier(11'd0);
		push_carrier(11'd1);
		push_carrier(11'd1535);
		push_carrier(11'd1536);
		push_carrier(11'd2047);
		push_carrier(11'd1024);
		push_carrier(11'h2AB);
		push_carrier(11'h554);

		// Each mode with its own FFT size, down to the smallest and up to the largest.
		configure(13'd512, {10'd0, MODE_512});
		push_carrier(11'd0);
		push_carrier(11'd383);
		push_carrier(11'd384);
		configure(13'd256, {10'd0, MODE_256});
		push_carrier(11'd191);
		push_carrier(11'd192);
		configure(13'd4096, {10'd0, MODE_1K});
		push_carrier(11'd0);
		push_carrier(11'd767);
		push_carrier(11'd768);

		// Undefined mode codes, one of them with every upper data bit set, must keep
		// the 1K table. An FFT size of zero and one of all ones make negative offsets wrap.
		configure(13'd0, {10'h3FF, 3'd0});
		push_carrier(11'd767);
		push_carrier(11'd2);
		configure(13'h1FFF, {10'd0, 3'd5});
		push_carrier(11'd5);
		configure(13'd1024, {10'h155, 3'd6});
		push_carrier(11'd700);
		configure(13'd3000, {10'h2AA, 3'd7});
		push_carrier(11'd100);

		// A defined mode with the upper data bits set is still taken as that mode.
		configure(13'h1FFF, {10'h3FF, MODE_2K});
		push_carrier(11'd1535);
		push_carrier(11'd3);

		// Random phases: a mode write (at times with an undefined code) and an FFT size each, then a stream of lookups.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if ($urandom_range(0, 6) == 0) begin
				pick = $urandom_range(0, 3);
				mode_word = {10'($urandom), (pick == 0) ? 3'd0 : MODE_W'(pick + 4)};
			end else begin
				mode_word = {10'($urandom), MODE_W'($urandom_range(1, 4))};
			end
			case ($urandom_range(0, 3))
				0, 1: fft = FFT_W'($urandom_range(256, 4096));
				2:    fft = FFT_W'(carriers_for(MODE_W'($urandom_range(1, 4))) * 4 / 3);
				default: fft = FFT_W'($urandom);
			endcase
			configure(fft, mode_word);
			k = carriers_for(live_mode);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Now and then the sender waits for every outstanding result.
				if ($urandom_range(0, 99) == 0)
					settle();
				push_carrier(pick_index(k));
			end
		end

		settle();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+sv
sv/oci_pkg.sv
sv/oci_if.sv
sv/oci_ram.sv
sv/oci_gen.sv
sv/ofdm_carrier_interleaver_core.sv
bench/oci_bin_checker.sv
bench/ofdm_carrier_interleaver_core_tb.sv
